// ----- src/multichannel_fir_decimator_core_defines.svh -----
// Assertion macros for the multichannel FIR decimator core.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef MULTICHANNEL_FIR_DECIMATOR_CORE_DEFINES_SVH
`define MULTICHANNEL_FIR_DECIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define MFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define MFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mfd_pkg.sv -----
// Shared types and constants for the multichannel FIR decimator core.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int MAX_TAPS     = 64;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 24;
    localparam int DECIM_LIMIT  = 64;
    localparam int HIST_FRAMES  = MAX_TAPS + DECIM_LIMIT;
    localparam int FRAC_BITS    = SAMPLE_BITS - 1;

    localparam int CH_W      = $clog2(MAX_CHANNELS);
    localparam int FRAME_AW  = $clog2(HIST_FRAMES);
    localparam int HIST_AW   = FRAME_AW + CH_W;
    localparam int HIST_DEPTH = HIST_FRAMES * MAX_CHANNELS;
    localparam int COEF_AW   = $clog2(MAX_TAPS);

    // Register and field widths fixed by the programming interface.
    localparam int TAP_W   = 7;
    localparam int CHCNT_W = 4;
    localparam int DEC_W   = 7;
    localparam int LAG_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W  = 2;
    localparam int CIDX_W  = 6;
    localparam int OUT_CH_W = 3;

    // Frame arithmetic: the counter, the counter plus one, and a signed
    // frame index that may fall below zero during the zero-padded lead-in.
    localparam int FRAME_CNT_W = 32;
    localparam int FRAME_X_W   = FRAME_CNT_W + 1;
    localparam int FRAME_J_W   = FRAME_CNT_W + 2;
    localparam int STEP_W      = $clog2(FRAME_X_W);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + COEF_AW;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(64'sd1 <<< FRAC_BITS));
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_COEF    = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_COUNT     = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_DECIMATION    = 2'd2,
        REG_LAG_FRAMES    = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [KIND_W-1:0]             kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CIDX_W-1:0]             coef_index;
        logic signed [SAMPLE_BITS-1:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [OUT_CH_W-1:0]           channel;
        logic                          clipped;
    } t_out_item;

endpackage

// ----- src/mfd_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; instantiated for the sample history and coefficients.
`timescale 1ns / 1ps

module mfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/multichannel_fir_decimator_core.sv -----
// Top level of the multichannel FIR decimator core.
// Depends on mfd_pkg, mfd_ram and multichannel_fir_decimator_core_defines.svh.
//
//   Channel   Direction  Handshake               Payload
//   input     in         i_in_valid / o_in_stall  i_in_item  (mfd_pkg::t_in_item)
//   output    out        o_out_valid / i_out_stall o_out_item (mfd_pkg::t_out_item)
//   config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// A coefficient load, an ignored kind, or a sample taken before lag plus
// decimation frames are in is handled in the idle state. Any later sample
// passes through the bit-serial remainder unit, and when it closes an output
// frame the shared multiply-accumulate walks the taps. A restart, and reset,
// run a clearing pass over the 1024 history words (reset also clears the
// coefficients) with input stalled. The finished result waits in an output
// register, so a stalled output only holds the block once the next result
// is ready.
`timescale 1ns / 1ps
`include "multichannel_fir_decimator_core_defines.svh"

module multichannel_fir_decimator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mfd_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mfd_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfd_pkg::CFG_W-1:0]   i_cfg_data
);

    // The sequencer: clear the history, wait for work, find whether the sample
    // closes an output frame, run the taps, let the pipeline empty, round, and
    // hand the result over.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_MAC,
        S_DRAIN,
        S_ROUND,
        S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers, stored raw and clamped where they are used.
    logic [mfd_pkg::TAP_W-1:0]   r_tap_count;
    logic [mfd_pkg::CHCNT_W-1:0] r_channel_count;
    logic [mfd_pkg::DEC_W-1:0]   r_decimation;
    logic [mfd_pkg::LAG_W-1:0]   r_lag_frames;

    // Stream position.
    logic [mfd_pkg::FRAME_CNT_W-1:0] r_frame_count;
    logic [mfd_pkg::CH_W-1:0]        r_channel_pos;

    // Clearing pass.
    logic [mfd_pkg::HIST_AW-1:0] r_clr_addr;
    logic                        r_clr_coef;

    // Per-transaction working copies.
    logic [mfd_pkg::CH_W-1:0]      r_pos;
    logic [mfd_pkg::TAP_W-1:0]     r_t;
    logic [mfd_pkg::DEC_W-1:0]     r_d;
    logic [mfd_pkg::FRAME_X_W-1:0] r_x;
    logic [mfd_pkg::DEC_W-1:0]     r_rem;
    logic [mfd_pkg::STEP_W-1:0]    r_step;
    logic signed [mfd_pkg::FRAME_J_W-1:0] r_j;
    logic [mfd_pkg::COEF_AW-1:0]   r_cidx;
    logic [mfd_pkg::TAP_W-1:0]     r_issue_left;

    // Multiply-accumulate pipeline: read, multiply, accumulate.
    logic                                 r_v1;
    logic                                 r_neg1;
    logic                                 r_v2;
    logic signed [mfd_pkg::PROD_W-1:0]    r_prod;
    logic signed [mfd_pkg::ACC_W-1:0]     r_acc;

    // Result waiting for the output handshake.
    mfd_pkg::t_out_item r_res;
    logic               r_out_valid;
    mfd_pkg::t_out_item r_out_item;

    // Clamped configuration and accept decode.
    logic [mfd_pkg::TAP_W-1:0]   c_t;
    logic [mfd_pkg::CHCNT_W-1:0] c_c;
    logic [mfd_pkg::DEC_W-1:0]   c_d;
    logic [mfd_pkg::LAG_W-1:0]   c_l;
    logic [mfd_pkg::CH_W-1:0]    c_pos;
    logic                        in_accept;
    logic                        acc_sample;
    logic                        acc_coef;
    logic                        acc_restart;
    logic                        emit_possible;
    logic [mfd_pkg::FRAME_X_W-1:0] frame_plus1;
    logic signed [mfd_pkg::FRAME_J_W-1:0] base_j;
    logic [mfd_pkg::DEC_W:0]     trial;
    logic [mfd_pkg::DEC_W-1:0]   n_rem;
    logic signed [mfd_pkg::ACC_W-1:0] rounded;
    logic signed [mfd_pkg::ACC_W-1:0] shifted;

    // Memory ports.
    logic                               hist_we;
    logic [mfd_pkg::HIST_AW-1:0]        hist_waddr;
    logic [mfd_pkg::SAMPLE_BITS-1:0]    hist_wdata;
    logic [mfd_pkg::HIST_AW-1:0]        hist_raddr;
    logic [mfd_pkg::SAMPLE_BITS-1:0]    hist_rdata;
    logic                               coef_we;
    logic [mfd_pkg::COEF_AW-1:0]        coef_waddr;
    logic [mfd_pkg::SAMPLE_BITS-1:0]    coef_wdata;
    logic [mfd_pkg::COEF_AW-1:0]        coef_raddr;
    logic [mfd_pkg::SAMPLE_BITS-1:0]    coef_rdata;

    always_comb begin
        // Out-of-range register values are pulled back into range.
        if (r_tap_count == '0) begin
            c_t = mfd_pkg::TAP_W'(1);
        end else if (r_tap_count > mfd_pkg::TAP_W'(mfd_pkg::MAX_TAPS)) begin
            c_t = mfd_pkg::TAP_W'(mfd_pkg::MAX_TAPS);
        end else begin
            c_t = r_tap_count;
        end
        if (r_channel_count == '0) begin
            c_c = mfd_pkg::CHCNT_W'(1);
        end else if (r_channel_count > mfd_pkg::CHCNT_W'(mfd_pkg::MAX_CHANNELS)) begin
            c_c = mfd_pkg::CHCNT_W'(mfd_pkg::MAX_CHANNELS);
        end else begin
            c_c = r_channel_count;
        end
        if (r_decimation == '0) begin
            c_d = mfd_pkg::DEC_W'(1);
        end else if (r_decimation > mfd_pkg::DEC_W'(mfd_pkg::DECIM_LIMIT)) begin
            c_d = mfd_pkg::DEC_W'(mfd_pkg::DECIM_LIMIT);
        end else begin
            c_d = r_decimation;
        end
        if (r_lag_frames > c_t) begin
            c_l = c_t;
        end else begin
            c_l = r_lag_frames;
        end
        // After a change of channel count a stray position restarts the frame.
        if ({1'b0, r_channel_pos} >= c_c) begin
            c_pos = '0;
        end else begin
            c_pos = r_channel_pos;
        end
    end

    assign in_accept   = i_in_valid && !o_in_stall;
    assign acc_sample  = in_accept && (i_in_item.kind == mfd_pkg::KIND_SAMPLE);
    assign acc_coef    = in_accept && (i_in_item.kind == mfd_pkg::KIND_COEF);
    assign acc_restart = in_accept && (i_in_item.kind == mfd_pkg::KIND_RESTART);

    // An output frame can close only once lag plus decimation frames are in.
    assign frame_plus1   = {1'b0, r_frame_count} + mfd_pkg::FRAME_X_W'(1);
    assign emit_possible = frame_plus1 >= (mfd_pkg::FRAME_X_W'(c_l)
                                           + mfd_pkg::FRAME_X_W'(c_d));

    // Oldest history frame that the taps touch; negative frames are padding.
    assign base_j = $signed({1'b0, frame_plus1})
                  - $signed(mfd_pkg::FRAME_J_W'(c_d))
                  - $signed(mfd_pkg::FRAME_J_W'(c_t));

    // One restoring step of the remainder of (frame + 1 - lag) by decimation.
    assign trial = {r_rem, r_x[mfd_pkg::FRAME_X_W-1]};
    always_comb begin
        if (trial >= {1'b0, r_d}) begin
            n_rem = mfd_pkg::DEC_W'(trial - {1'b0, r_d});
        end else begin
            n_rem = trial[mfd_pkg::DEC_W-1:0];
        end
    end

    // Round half up at the last kept bit, then saturate.
    assign rounded = r_acc + mfd_pkg::ROUND_HALF;
    assign shifted = rounded >>> mfd_pkg::FRAC_BITS;

    // History memory: cleared by the sweep, written by each accepted sample.
    always_comb begin
        if (r_state == S_CLEAR) begin
            hist_we    = 1'b1;
            hist_waddr = r_clr_addr;
            hist_wdata = '0;
        end else begin
            hist_we    = acc_sample;
            hist_waddr = {r_frame_count[mfd_pkg::FRAME_AW-1:0], c_pos};
            hist_wdata = i_in_item.sample;
        end
        if ((r_state == S_CLEAR) && r_clr_coef) begin
            coef_we    = r_clr_addr < mfd_pkg::HIST_AW'(mfd_pkg::MAX_TAPS);
            coef_waddr = r_clr_addr[mfd_pkg::COEF_AW-1:0];
            coef_wdata = '0;
        end else begin
            coef_we    = acc_coef;
            coef_waddr = i_in_item.coef_index[mfd_pkg::COEF_AW-1:0];
            coef_wdata = i_in_item.coef_value;
        end
    end

    assign hist_raddr = {r_j[mfd_pkg::FRAME_AW-1:0], r_pos};
    assign coef_raddr = r_cidx;

    mfd_ram #(
        .WIDTH(mfd_pkg::SAMPLE_BITS),
        .DEPTH(mfd_pkg::HIST_DEPTH)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (hist_we),
        .i_waddr(hist_waddr),
        .i_wdata(hist_wdata),
        .i_raddr(hist_raddr),
        .o_rdata(hist_rdata)
    );

    mfd_ram #(
        .WIDTH(mfd_pkg::SAMPLE_BITS),
        .DEPTH(mfd_pkg::MAX_TAPS)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(coef_waddr),
        .i_wdata(coef_wdata),
        .i_raddr(coef_raddr),
        .o_rdata(coef_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_tap_count     <= mfd_pkg::TAP_W'(1);
            r_channel_count <= mfd_pkg::CHCNT_W'(1);
            r_decimation    <= mfd_pkg::DEC_W'(1);
            r_lag_frames    <= '0;
            r_frame_count   <= '0;
            r_channel_pos   <= '0;
            r_clr_addr      <= '0;
            r_clr_coef      <= 1'b1;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            // Configuration writes are taken in any state.
            if (i_cfg_we) begin
                case (mfd_pkg::t_reg_index'(i_cfg_index))
                    mfd_pkg::REG_TAP_COUNT:     r_tap_count     <= i_cfg_data;
                    mfd_pkg::REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[mfd_pkg::CHCNT_W-1:0];
                    mfd_pkg::REG_DECIMATION:    r_decimation    <= i_cfg_data;
                    mfd_pkg::REG_LAG_FRAMES:    r_lag_frames    <= i_cfg_data;
                    default: ;
                endcase
            end

            // Multiply-accumulate pipeline runs freely behind the tap issue.
            r_v1   <= (r_state == S_MAC);
            r_neg1 <= r_j[mfd_pkg::FRAME_J_W-1];
            r_v2   <= r_v1;
            if (r_v1) begin
                if (r_neg1) begin
                    r_prod <= '0;
                end else begin
                    r_prod <= $signed(hist_rdata) * $signed(coef_rdata);
                end
            end
            if (r_v2) begin
                r_acc <= r_acc + mfd_pkg::ACC_W'(r_prod);
            end

            // The hand-over state reloads the output register itself.
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + mfd_pkg::HIST_AW'(1);
                    if (r_clr_addr == {mfd_pkg::HIST_AW{1'b1}}) begin
                        r_clr_coef <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc_restart) begin
                        r_frame_count <= '0;
                        r_channel_pos <= '0;
                        r_clr_addr    <= '0;
                        r_clr_coef    <= 1'b0;
                        r_state       <= S_CLEAR;
                    end else if (acc_sample) begin
                        r_pos  <= c_pos;
                        r_t    <= c_t;
                        r_d    <= c_d;
                        r_j    <= base_j;
                        r_x    <= frame_plus1 - mfd_pkg::FRAME_X_W'(c_l);
                        r_rem  <= '0;
                        r_step <= mfd_pkg::STEP_W'(mfd_pkg::FRAME_X_W - 1);
                        if ({1'b0, c_pos} + mfd_pkg::CHCNT_W'(1) >= c_c) begin
                            r_channel_pos <= '0;
                            r_frame_count <= r_frame_count + mfd_pkg::FRAME_CNT_W'(1);
                        end else begin
                            r_channel_pos <= c_pos + mfd_pkg::CH_W'(1);
                        end
                        if (emit_possible) begin
                            r_state <= S_DIVIDE;
                        end
                    end
                end
                S_DIVIDE: begin
                    r_rem  <= n_rem;
                    r_x    <= {r_x[mfd_pkg::FRAME_X_W-2:0], 1'b0};
                    r_step <= r_step - mfd_pkg::STEP_W'(1);
                    if (r_step == '0) begin
                        if (n_rem == '0) begin
                            r_cidx       <= mfd_pkg::COEF_AW'(r_t - mfd_pkg::TAP_W'(1));
                            r_issue_left <= r_t;
                            r_acc        <= '0;
                            r_state      <= S_MAC;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MAC: begin
                    r_j          <= r_j + mfd_pkg::FRAME_J_W'(1);
                    r_cidx       <= r_cidx - mfd_pkg::COEF_AW'(1);
                    r_issue_left <= r_issue_left - mfd_pkg::TAP_W'(1);
                    if (r_issue_left == mfd_pkg::TAP_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_res.channel <= mfd_pkg::OUT_CH_W'(r_pos);
                    if (shifted > mfd_pkg::SAT_MAX) begin
                        r_res.value   <= mfd_pkg::SAMPLE_BITS'(mfd_pkg::SAT_MAX);
                        r_res.clipped <= 1'b1;
                    end else if (shifted < mfd_pkg::SAT_MIN) begin
                        r_res.value   <= mfd_pkg::SAMPLE_BITS'(mfd_pkg::SAT_MIN);
                        r_res.clipped <= 1'b1;
                    end else begin
                        r_res.value   <= shifted[mfd_pkg::SAMPLE_BITS-1:0];
                        r_res.clipped <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A new result only appears as the hand-over state completes.
    `MFD_ASSERT_NOW(a_out_from_emit, $rose(o_out_valid), $past(r_state) == S_EMIT, "result without hand-over")
    // The remainder unit never holds a value at or above the decimation.
    `MFD_ASSERT_NOW(a_rem_range, r_state == S_DIVIDE, r_rem < r_d, "remainder out of range")
    // Taps are only issued while some remain.
    `MFD_ASSERT_NOW(a_issue_count, r_state == S_MAC, r_issue_left != '0, "tap issue overrun")
    // Rounding starts only with the multiply pipeline empty.
    `MFD_ASSERT_NEXT(a_drain_done, r_state == S_DRAIN && !r_v1 && !r_v2, !r_v1 && !r_v2, "pipeline busy at rounding")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the multichannel FIR decimator core.
// Depends on mfd_pkg and multichannel_fir_decimator_core; it reads no files.
`timescale 1ns / 1ps

module tb;
    import mfd_pkg::*;

    // Clock period is 4 ns; reset is held only at the start of the run.
    localparam int RESET_CYCLES = 9;
    // A restart or reset clears 1024 history words; the wait also covers a tap walk.
    localparam int SETTLE_CYCLES = 1100;
    // Longest wait for outstanding results before they are declared missing.
    localparam int DRAIN_LIMIT = 50000;
    // Generous bound on the length of the whole run.
    localparam int CYCLE_LIMIT = 2000000;

    // The kind code that the block must ignore.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] Q_POS_FULL = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] Q_NEG_FULL = 24'sh800000;
    localparam logic signed [SAMPLE_BITS-1:0] Q_HALF_LSB = 24'sh400000;

    localparam longint SUM_MAX    = (longint'(1) <<< FRAC_BITS) - longint'(1);
    localparam longint SUM_MIN    = -(longint'(1) <<< FRAC_BITS);
    localparam longint ROUND_BIAS = longint'(1) <<< (FRAC_BITS - 1);
    localparam longint unsigned HIST_SPAN = longint'(HIST_FRAMES);
    localparam longint unsigned TAP_LIMIT = longint'(MAX_TAPS);
    localparam longint unsigned CHAN_LIMIT = longint'(MAX_CHANNELS);
    localparam longint unsigned DEC_LIMIT = longint'(DECIM_LIMIT);

    // Every input of the block starts at a known value.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_TAP_COUNT;
    logic [CFG_W-1:0]       cfg_data  = '0;

    // Idle percentages of the sender and the receiver; the test sequence
    // changes them between stretches of the run.
    int tx_idle_pct  = 36;
    int rx_idle_pct  = 68;
    // A long receiver hold-off is requested here and counted down by the
    // process that drives the output stall.
    int hold_request = 0;
    int hold_left    = 0;

    int cycle_count = 0;
    int fail_count  = 0;

    // Private copy of the filter state, kept in step with every transaction
    // that the block accepts.
    logic signed [SAMPLE_BITS-1:0] shadow_history [HIST_FRAMES][MAX_CHANNELS];
    logic signed [SAMPLE_BITS-1:0] shadow_coefs [MAX_TAPS];
    logic [31:0]                   shadow_frames;
    longint unsigned               shadow_chan;
    longint unsigned               shadow_taps, shadow_chans, shadow_decim, shadow_lag;

    // Filtered samples that the block owes, oldest first.
    t_out_item pending_fir_out [$];

    multichannel_fir_decimator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // The run is abandoned if it goes on far longer than any correct run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver side. A requested hold-off keeps the output stalled for its
    // full count, so the block fills up and has to stall its input; otherwise
    // the stall follows the current idle percentage.
    always @(posedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Only the first ten failures are described; the rest are counted.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // Every output transaction is compared, field by field, with the oldest
    // filtered sample still owed. Inputs and outputs are both sampled in the
    // active region just after the edge, so they hold their pre-edge values.
    always @(posedge clk) begin : check_fir_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_fir_out.size() == 0) begin
                note_failure($sformatf("unexpected result: value %0d channel %0d clipped %0b",
                                       out_item.value, out_item.channel, out_item.clipped));
            end else begin
                want = pending_fir_out.pop_front();
                if (want.value !== out_item.value || want.channel !== out_item.channel ||
                    want.clipped !== out_item.clipped) begin
                    note_failure($sformatf({"result mismatch: expected value %0d channel %0d ",
                                            "clipped %0b, got value %0d channel %0d clipped %0b"},
                                           want.value, want.channel, want.clipped,
                                           out_item.value, out_item.channel, out_item.clipped));
                end
            end
        end
    end

    // A restart wipes the sample history and rewinds the frame position.
    function automatic void clear_stream();
        foreach (shadow_history[f, c]) begin
            shadow_history[f][c] = '0;
        end
        shadow_frames = '0;
        shadow_chan   = 0;
    endfunction

    // Reset behaves as a restart that also clears the coefficients and
    // returns the registers to their defaults.
    function automatic void reset_shadow();
        clear_stream();
        foreach (shadow_coefs[i]) begin
            shadow_coefs[i] = '0;
        end
        shadow_taps  = 1;
        shadow_chans = 1;
        shadow_decim = 1;
        shadow_lag   = 0;
    endfunction

    // Works out what one accepted input transaction does to the filter and,
    // when a sample closes an output frame, which filtered sample it owes.
    function automatic void predict_fir_output(input t_in_item item);
        longint unsigned taps, chans, decim, lag, pos, frame, k, q, pad;
        longint          acc, scaled;
        t_out_item       res;
        case (item.kind)
            KIND_COEF: begin
                shadow_coefs[item.coef_index] = item.coef_value;
            end
            KIND_RESTART: begin
                clear_stream();
            end
            KIND_SAMPLE: begin
                // Out-of-range registers are clamped into their legal ranges,
                // and the lag never exceeds the tap count.
                taps  = (shadow_taps < 1) ? 1 : ((shadow_taps > TAP_LIMIT) ? TAP_LIMIT
                                                                            : shadow_taps);
                chans = (shadow_chans < 1) ? 1 : ((shadow_chans > CHAN_LIMIT) ? CHAN_LIMIT
                                                                               : shadow_chans);
                decim = (shadow_decim < 1) ? 1 : ((shadow_decim > DEC_LIMIT) ? DEC_LIMIT
                                                                              : shadow_decim);
                lag   = (shadow_lag > taps) ? taps : shadow_lag;
                // A channel position left beyond a reduced channel count
                // falls back to channel zero of the current frame.
                pos   = (shadow_chan >= chans) ? 0 : shadow_chan;
                frame = longint'(shadow_frames);
                shadow_history[FRAME_AW'(frame % HIST_SPAN)][CH_W'(pos)] = item.sample;
                if (frame + 1 >= lag + decim && (frame + 1 - lag) % decim == 0) begin
                    k   = (frame + 1 - lag) / decim - 1;
                    pad = taps - lag;
                    acc = 0;
                    // Frames in the zero padding contribute nothing.
                    for (longint unsigned i = 0; i < taps; i++) begin
                        q = k * decim + i;
                        if (q >= pad) begin
                            acc += longint'(shadow_history[FRAME_AW'((q - pad) % HIST_SPAN)]
                                                          [CH_W'(pos)])
                                 * longint'(shadow_coefs[COEF_AW'(taps - 1 - i)]);
                        end
                    end
                    // Round half towards plus infinity, then saturate.
                    scaled      = (acc + ROUND_BIAS) >>> FRAC_BITS;
                    res.clipped = 1'b0;
                    if (scaled > SUM_MAX) begin
                        scaled      = SUM_MAX;
                        res.clipped = 1'b1;
                    end else if (scaled < SUM_MIN) begin
                        scaled      = SUM_MIN;
                        res.clipped = 1'b1;
                    end
                    res.value   = scaled[SAMPLE_BITS-1:0];
                    res.channel = pos[OUT_CH_W-1:0];
                    pending_fir_out.push_back(res);
                end
                if (pos + 1 >= chans) begin
                    shadow_chan   = 0;
                    shadow_frames = shadow_frames + 32'd1;
                end else begin
                    shadow_chan = pos + 1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Offers one input transaction after a random idle gap and waits until
    // it is taken. Valid stays high between back-to-back transactions.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        predict_fir_output(item);
    endtask

    // Directed transaction: the value goes to the sample or the coefficient
    // field according to the kind, the slot to the coefficient index; the other value field carries zero.
    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [SAMPLE_BITS-1:0] value,
                           input logic [CIDX_W-1:0] slot);
        t_in_item item;
        item            = '0;
        item.kind       = kind;
        item.coef_index = slot;
        if (kind == KIND_COEF) begin
            item.coef_value = value;
        end else begin
            item.sample = value;
        end
        send_item(item);
    endtask

    // Q1.23 values weighted towards the extremes, with many smaller
    // magnitudes so that not every long sum saturates.
    function automatic logic signed [SAMPLE_BITS-1:0] rand_q123();
        logic signed [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_POS_FULL;
            1: v = Q_NEG_FULL;
            2: v = '0;
            3: v = $urandom_range(0, 1) ? 24'sh000001 : 24'shFFFFFF;
            default: begin
                v = SAMPLE_BITS'($urandom());
                v = v >>> $urandom_range(0, 12);
            end
        endcase
        return v;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 84) begin
            return KIND_SAMPLE;
        end else if (roll < 93) begin
            return KIND_COEF;
        end else if (roll < 96) begin
            return KIND_RESTART;
        end
        return KIND_UNKNOWN;
    endfunction

    // Random transaction of the given kind; fields the kind does not use
    // carry random noise.
    function automatic t_in_item random_item(input logic [KIND_W-1:0] kind);
        t_in_item item;
        item.kind       = kind;
        item.sample     = rand_q123();
        item.coef_index = CIDX_W'($urandom_range(0, MAX_TAPS - 1));
        item.coef_value = rand_q123();
        return item;
    endfunction

    // One register write per cycle; the enable drops after the last one.
    task automatic drive_reg(input t_reg_index idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_TAP_COUNT:     shadow_taps  = longint'(data);
            REG_CHANNEL_COUNT: shadow_chans = longint'(data[CHCNT_W-1:0]);
            REG_DECIMATION:    shadow_decim = longint'(data);
            REG_LAG_FRAMES:    shadow_lag   = longint'(data);
            default: begin
            end
        endcase
    endtask

    task automatic write_config(input logic [CFG_W-1:0] taps, chans, decim, lag);
        drive_reg(REG_TAP_COUNT, taps);
        drive_reg(REG_CHANNEL_COUNT, chans);
        drive_reg(REG_DECIMATION, decim);
        drive_reg(REG_LAG_FRAMES, lag);
        cfg_we <= 1'b0;
    endtask

    // Brings the block to rest: stops offering input, waits for every owed
    // result, then lets a restart clearing pass or a tap walk run out.
    task automatic wait_idle();
        int waited;
        waited   = 0;
        in_valid <= 1'b0;
        while (pending_fir_out.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_fir_out.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_fir_out.size()));
            pending_fir_out.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rounding at exactly one half, at minus one half and just below it, then
    // saturation in both directions and a full-scale product that just fits.
    task automatic test_rounding_and_clipping();
        wait_idle();
        write_config(7'd1, 7'd1, 7'd1, 7'd0);
        send_op(KIND_COEF, 24'sh000001, 6'd0);
        send_op(KIND_SAMPLE, Q_HALF_LSB, 6'd0);
        send_op(KIND_SAMPLE, -Q_HALF_LSB, 6'd0);
        send_op(KIND_SAMPLE, -Q_HALF_LSB - 24'sd1, 6'd0);
        send_op(KIND_COEF, Q_NEG_FULL, 6'd0);
        send_op(KIND_SAMPLE, Q_NEG_FULL, 6'd0);
        send_op(KIND_SAMPLE, Q_POS_FULL, 6'd0);
        // Two negative full-scale products drive the sum below range.
        wait_idle();
        write_config(7'd2, 7'd1, 7'd1, 7'd0);
        send_op(KIND_COEF, Q_NEG_FULL, 6'd1);
        send_op(KIND_SAMPLE, Q_POS_FULL, 6'd0);
        send_op(KIND_SAMPLE, Q_POS_FULL, 6'd0);
        send_op(KIND_SAMPLE, Q_POS_FULL, 6'd0);
        send_op(KIND_SAMPLE, Q_NEG_FULL, 6'd0);
    endtask

    // Registers written below and above their legal ranges, and a lag
    // larger than the tap count.
    task automatic test_register_limits();
        wait_idle();
        write_config(7'd0, 7'd0, 7'd0, 7'd5);
        send_op(KIND_SAMPLE, 24'sh123456, 6'd0);
        send_op(KIND_SAMPLE, 24'shABCDEF, 6'd0);
        wait_idle();
        write_config(7'd127, 7'd15, 7'd127, 7'd127);
        send_op(KIND_SAMPLE, Q_POS_FULL, 6'd0);
    endtask

    // Shrinking the channel count mid-frame: the next sample is taken as
    // channel zero of the same frame.
    task automatic test_channel_realignment();
        wait_idle();
        write_config(7'd2, 7'd8, 7'd1, 7'd0);
        send_op(KIND_SAMPLE, 24'sh0F0F0F, 6'd0);
        send_op(KIND_SAMPLE, 24'sh70F0F0, 6'd0);
        send_op(KIND_SAMPLE, 24'sh800001, 6'd0);
        wait_idle();
        write_config(7'd2, 7'd2, 7'd1, 7'd0);
        send_op(KIND_SAMPLE, 24'sh2AAAAA, 6'd0);
        send_op(KIND_SAMPLE, 24'shD55555, 6'd0);
        send_op(KIND_SAMPLE, 24'sh000100, 6'd0);
    endtask

    // An ignored kind, the highest coefficient slot, and a restart that keeps
    // coefficients and registers but drops the history.
    task automatic test_stream_control();
        send_op(KIND_UNKNOWN, Q_POS_FULL, 6'd63);
        send_op(KIND_COEF, Q_POS_FULL, 6'd63);
        send_op(KIND_RESTART, Q_NEG_FULL, 6'd63);
        send_op(KIND_SAMPLE, 24'sh3FFFFF, 6'd0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering a result-producing sample in every transaction.
    task automatic test_output_backpressure();
        wait_idle();
        write_config(7'd1, 7'd1, 7'd1, 7'd0);
        hold_request = 1500;
        for (int n = 0; n < 30; n++) begin
            send_item(random_item(KIND_SAMPLE));
        end
    endtask

    // One setting of the registers: an optional full coefficient load, then
    // a random mix dominated by samples.
    task automatic run_phase(input logic [CFG_W-1:0] taps, chans, decim, lag,
                             input int n_items);
        int unsigned live_taps;
        t_in_item    item;
        wait_idle();
        write_config(taps, chans, decim, lag);
        live_taps = (taps < 7'd1) ? 1 : ((taps > 7'd64) ? MAX_TAPS : int'(taps));
        if ($urandom_range(0, 1) == 1) begin
            for (int unsigned i = 0; i < live_taps; i++) begin
                item            = random_item(KIND_COEF);
                item.coef_index = CIDX_W'(i);
                send_item(item);
            end
        end
        for (int n = 0; n < n_items; n++) begin
            send_item(random_item(pick_kind()));
        end
    endtask

    // Random streams over many register settings, extremes among them. The
    // idling pattern changes per third: sender light and receiver heavy, then
    // the reverse, then no idling at all.
    task automatic test_random_streams();
        run_phase(7'd8, 7'd3, 7'd2, 7'd2, 100);
        run_phase(7'd64, 7'd1, 7'd64, 7'd64, 240);
        run_phase(7'd0, 7'd0, 7'd0, 7'd0, 50);
        run_phase(7'd127, 7'd15, 7'd3, 7'd9, 130);
        tx_idle_pct = 68;
        rx_idle_pct = 36;
        run_phase(7'd3, 7'd5, 7'd1, 7'd100, 100);
        run_phase(7'd1, 7'd1, 7'd127, 7'd1, 160);
        run_phase(7'd16, 7'd2, 7'd4, 7'd0, 120);
        run_phase(7'd64, 7'd8, 7'd1, 7'd0, 120);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(7'd5, 7'd4, 7'd3, 7'd5, 120);
        run_phase(7'd32, 7'd6, 7'd2, 7'd10, 120);
        run_phase(7'd2, 7'd7, 7'd1, 7'd1, 90);
        run_phase(7'd12, 7'd1, 7'd5, 7'd3, 90);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        reset_shadow();
        test_rounding_and_clipping();
        test_register_limits();
        test_channel_realignment();
        test_stream_control();
        test_output_backpressure();
        test_random_streams();
        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
